### hdl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher block.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

    localparam int KL_W = 9;   // key length register width

    localparam logic [KL_W-1:0] KEY_LEN_MIN   = 9'd5;
    localparam logic [KL_W-1:0] KEY_LEN_MAX   = 9'd256;
    localparam logic [KL_W-1:0] KEY_LEN_RESET = 9'd16;

    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_value;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA_J,
        ST_DATA_SWAP,
        ST_DATA_OUT,
        ST_SCH_READ,
        ST_SCH_ACC,
        ST_SCH_WN,
        ST_SCH_WA
    } state_t;

endpackage

`default_nettype wire

### hdl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 keystream generator and XOR. Key bytes load a key memory; the key
// schedule then permutes a 256 x 8 state memory. Data bytes are XORed.
// ----------------------------------------------------------------------------
// Data byte: DATA_J, DATA_SWAP, DATA_OUT, set by the S[i], S[j], S[S[i]+S[j]]
//   read chain on the single read port; DATA_OUT loads the result and takes
//   the next byte once the output is free. Key byte: stored, and the last
//   of the key adds the schedule, 256 steps limited by state memory ports.
// Reset: permutation reads as identity (per-entry valid bits), indices and
//   key count cleared, key_length = 16. The key memory is not cleared.
`default_nettype none

module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 256
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    // input item channel
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire item_t           item,
    // result channel
    output logic                 result_valid,
    input  wire logic            result_ready,
    output result_t              result,
    // key length register write
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [KL_W-1:0] cfg_data
);

    localparam int KA = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CW = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [KL_W-1:0] MAX_KEY = KL_W'(MAX_KEY_BYTES);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t          state_reg, state_next;
    logic [KL_W-1:0] key_length_reg;
    logic [CW-1:0]   key_count_reg;
    logic [7:0]      i_reg, j_reg;
    logic [7:0]      si_reg;      // S[i] for data, S[n] for the schedule
    logic [7:0]      t_reg;       // keystream address S[i]+S[j]
    logic [7:0]      byte_reg;
    logic            eom_reg;
    logic [7:0]      n_reg;       // schedule step
    logic [7:0]      acc_reg;     // schedule j
    logic [KA-1:0]   kidx_reg;    // n mod key length, kept as a counter

    logic            result_valid_reg;
    result_t         result_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic [7:0]      perm_mem [256];
    logic [7:0]      key_mem  [MAX_KEY_BYTES];
    logic [255:0]    perm_valid_reg;  // clear: entry reads as its own index

    logic [7:0]      perm_q_reg;
    logic [7:0]      perm_addr_reg;
    logic            perm_vld_reg;
    logic            byp_reg;         // read collided with a write
    logic [7:0]      byp_data_reg;
    logic [7:0]      key_q_reg;

    logic            perm_rd_en;
    logic [7:0]      perm_rd_addr;
    logic            perm_wr_en;
    logic [7:0]      perm_wr_addr;
    logic [7:0]      perm_wr_data;
    logic            key_rd_en;
    logic            result_load;
    logic            out_free;
    logic            item_accept;
    logic            sched_start;
    logic            key_trigger;
    logic [KL_W-1:0] cnt_inc;
    logic [KL_W-1:0] sched_len;
    logic [7:0]      rd_val;
    logic [7:0]      ks;
    logic [7:0]      acc_sum;
    logic            cfg_ok;

    // read data: bypass of a same-edge write, then memory or identity
    assign rd_val = byp_reg      ? byp_data_reg :
                    perm_vld_reg ? perm_q_reg   : perm_addr_reg;

    assign out_free    = !result_valid_reg || result_ready;
    assign item_accept = item_valid && item_ready;

    // key count check: schedule once the count reaches the length
    assign cnt_inc     = KL_W'(key_count_reg) + KL_W'(1);
    assign key_trigger = (cnt_inc >= key_length_reg) || (cnt_inc >= MAX_KEY);
    assign sched_start = item_accept && (item.mode == MODE_KEY) && key_trigger;
    assign sched_len   = (key_length_reg > MAX_KEY) ? MAX_KEY : key_length_reg;

    // S[j] is written in the output cycle, so a keystream hit on j takes S[i]
    assign ks      = (t_reg == j_reg) ? si_reg : rd_val;
    assign acc_sum = acc_reg + rd_val + key_q_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE, ST_DATA_OUT:
            begin
                if (state_reg == ST_DATA_OUT && !out_free)
                    state_next = ST_DATA_OUT;
                else if (item_accept && item.mode == MODE_DATA)
                    state_next = ST_DATA_J;
                else if (sched_start)
                    state_next = ST_SCH_READ;
                else
                    state_next = ST_IDLE;
            end
            ST_DATA_J:    state_next = ST_DATA_SWAP;
            ST_DATA_SWAP: state_next = ST_DATA_OUT;
            ST_SCH_READ:  state_next = ST_SCH_ACC;
            ST_SCH_ACC:   state_next = ST_SCH_WN;
            ST_SCH_WN:    state_next = ST_SCH_WA;
            ST_SCH_WA:    state_next = (n_reg == 8'hFF) ? ST_IDLE : ST_SCH_READ;
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs: handshake and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        item_ready   = 1'b0;
        perm_rd_en   = 1'b0;
        perm_rd_addr = 8'd0;
        perm_wr_en   = 1'b0;
        perm_wr_addr = 8'd0;
        perm_wr_data = 8'd0;
        key_rd_en    = 1'b0;
        result_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            ST_DATA_J:
            begin
                perm_rd_en   = 1'b1;
                perm_rd_addr = j_reg + rd_val;
            end
            ST_DATA_SWAP:
            begin
                perm_wr_en   = 1'b1;
                perm_wr_addr = i_reg;
                perm_wr_data = rd_val;
                perm_rd_en   = 1'b1;
                perm_rd_addr = si_reg + rd_val;
            end
            ST_DATA_OUT:
            begin
                item_ready   = out_free;
                result_load  = out_free;
                perm_wr_en   = 1'b1;
                perm_wr_addr = j_reg;
                perm_wr_data = si_reg;
            end
            ST_SCH_READ:
            begin
                perm_rd_en   = 1'b1;
                perm_rd_addr = n_reg;
                key_rd_en    = 1'b1;
            end
            ST_SCH_ACC:
            begin
                perm_rd_en   = 1'b1;
                perm_rd_addr = acc_sum;
            end
            ST_SCH_WN:
            begin
                perm_wr_en   = 1'b1;
                perm_wr_addr = n_reg;
                perm_wr_data = rd_val;
            end
            ST_SCH_WA:
            begin
                perm_wr_en   = 1'b1;
                perm_wr_addr = acc_reg;
                perm_wr_data = si_reg;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
        // first read of a data transaction goes out on the accepting edge
        if (item_accept && item.mode == MODE_DATA)
        begin
            perm_rd_en   = 1'b1;
            perm_rd_addr = i_reg + 8'd1;
        end
    end

    // ------------------------------------------------------------------
    // Permutation memory, one write and one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (perm_wr_en)
            perm_mem[perm_wr_addr] <= perm_wr_data;
        if (perm_rd_en)
        begin
            perm_q_reg    <= perm_mem[perm_rd_addr];
            perm_addr_reg <= perm_rd_addr;
            perm_vld_reg  <= perm_valid_reg[perm_rd_addr];
            byp_reg       <= perm_wr_en && (perm_wr_addr == perm_rd_addr);
            byp_data_reg  <= perm_wr_data;
        end
    end

    // valid bits: cleared at reset and when a key schedule starts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            perm_valid_reg <= '0;
        else if (sched_start)
            perm_valid_reg <= '0;
        else if (perm_wr_en)
            perm_valid_reg[perm_wr_addr] <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Key memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item_accept && item.mode == MODE_KEY)
            key_mem[key_count_reg[KA-1:0]] <= item.byte_value;
        if (key_rd_en)
            key_q_reg <= key_mem[kidx_reg];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_ok    = (cfg_data >= KEY_LEN_MIN) && (cfg_data <= KEY_LEN_MAX) &&
                       (cfg_data <= MAX_KEY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            key_length_reg   <= KEY_LEN_RESET;
            key_count_reg    <= '0;
            i_reg            <= 8'd0;
            j_reg            <= 8'd0;
            n_reg            <= 8'd0;
            acc_reg          <= 8'd0;
            kidx_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // out-of-range writes are dropped
            if (cfg_valid && cfg_ready && cfg_ok)
                key_length_reg <= cfg_data;

            if (item_accept && item.mode == MODE_KEY)
                key_count_reg <= key_trigger ? '0 : CW'(cnt_inc);

            if (item_accept && item.mode == MODE_DATA)
                i_reg <= i_reg + 8'd1;
            if (state_reg == ST_DATA_J)
                j_reg <= j_reg + rd_val;

            if (sched_start)
            begin
                n_reg    <= 8'd0;
                acc_reg  <= 8'd0;
                kidx_reg <= '0;
            end
            if (state_reg == ST_SCH_ACC)
                acc_reg <= acc_sum;
            if (state_reg == ST_SCH_WA)
            begin
                n_reg    <= n_reg + 8'd1;
                kidx_reg <= (KL_W'(kidx_reg) + KL_W'(1) >= sched_len) ?
                            '0 : kidx_reg + KA'(1);
                if (n_reg == 8'hFF)
                begin
                    i_reg <= 8'd0;
                    j_reg <= 8'd0;
                end
            end

            if (result_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            byte_reg <= item.byte_value;
            eom_reg  <= item.end_of_message;
        end
        if (state_reg == ST_DATA_J || state_reg == ST_SCH_ACC)
            si_reg <= rd_val;
        if (state_reg == ST_DATA_SWAP)
            t_reg <= si_reg + rd_val;
        if (result_load)
        begin
            result_reg.out_byte  <= byte_reg ^ ks;
            result_reg.last_byte <= eom_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
